// File: hw/rtl/vpd_pkg.sv
// Package of the vector pair distance unit: widths, register indexes, mode codes,
// and the command/status structs between controller and datapath. No dependencies.
package vpd_pkg;

  localparam int ELEM_BITS_DEF = 12;
  localparam int MAX_DIM_DEF   = 64;
  localparam int WDIM          = 64;
  localparam int WIDX_W        = 6;
  localparam int W_BITS        = 16;
  localparam int DIST_W        = 26;
  localparam int ACC_W         = 64;
  localparam int ROOT_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_P     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] MODE_MAX   = 3'd0;
  localparam logic [CFG_DATA_W-1:0] MODE_MANH  = 3'd1;
  localparam logic [CFG_DATA_W-1:0] MODE_EUCL  = 3'd2;
  localparam logic [CFG_DATA_W-1:0] MODE_MINK  = 3'd3;
  localparam logic [CFG_DATA_W-1:0] MODE_MAHA  = 3'd4;
  localparam logic [CFG_DATA_W-1:0] POWER_RST  = 3'd3;
  localparam logic [CFG_DATA_W-1:0] POWER_QUAD = 3'd4;

  localparam logic REQ_PAIR   = 1'b0;
  localparam logic REQ_WEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ROOT_SQ   = 2'd0,
    ROOT_CUBE = 2'd1,
    ROOT_QUAD = 2'd2
  } root_k_e;

  typedef struct packed {
    logic    pair_take;
    logic    wgt_take;
    logic    mul_sq;
    logic    mul_pw;
    logic    acc_upd;
    logic    res_acc;
    logic    res_root;
    logic    m_init;
    logic    m_rd_row;
    logic    m_prod;
    logic    m_row;
    logic    m_rd_di;
    logic    m_dmul;
    logic    m_q;
    logic    root_start;
    logic    root_q_src;
    root_k_e root_k;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic root_done;
    logic out_free;
  } sts_t;

  function automatic logic is_quad(logic [CFG_DATA_W-1:0] p);
    return p >= POWER_QUAD;
  endfunction

endpackage

// File: hw/rtl/vpd_req_if.sv
// Request channel of the vector pair distance unit: element pair or weight word.
// Depends on vpd_pkg.
interface vpd_req_if #(
  parameter int ELEM_BITS = vpd_pkg::ELEM_BITS_DEF
);
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic signed [ELEM_BITS-1:0]        x_value;
  logic signed [ELEM_BITS-1:0]        y_value;
  logic                               last_elem;
  logic [vpd_pkg::WIDX_W-1:0]         weight_row;
  logic [vpd_pkg::WIDX_W-1:0]         weight_col;
  logic signed [vpd_pkg::W_BITS-1:0]  weight_value;

  modport source (
    output valid, req_type, x_value, y_value, last_elem, weight_row, weight_col, weight_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, x_value, y_value, last_elem, weight_row, weight_col, weight_value,
    output ready
  );
endinterface

// File: hw/rtl/vpd_rsp_if.sv
// Result channel of the vector pair distance unit: distance and too_long flag.
// Depends on vpd_pkg.
interface vpd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [vpd_pkg::DIST_W-1:0]   distance;
  logic                         too_long;

  modport source (output valid, distance, too_long, input ready);
  modport sink (input valid, distance, too_long, output ready);
endinterface

// File: hw/rtl/vector_pair_distance_unit_top.sv
// Top level of the vector pair distance unit: configuration registers, controller
// and datapath. Depends on vpd_pkg, vpd_req_if, vpd_rsp_if, vpd_ctrl, vpd_dp.
//
// One request at a time. A weight word is taken without leaving the idle state. An
// element pair occupies the unit through intake, square, power and accumulate. On
// the last pair a finish step follows, then: maximum and manhattan go straight to
// the output; euclidean runs the root unit for 32 result bits, minkowski for 22
// bits (p = 3) or 16 bits (p = 4); mahalanobis first runs the quadratic form over
// n stored differences, one weight-memory read per product, then the square root.
// The result sits in an output register, so the next vector is accepted while it
// waits; a last pair stalls only if the previous result has not been taken.
module vector_pair_distance_unit_top #(
  parameter int ELEM_BITS = vpd_pkg::ELEM_BITS_DEF,
  parameter int MAX_DIM   = vpd_pkg::MAX_DIM_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  vpd_req_if.sink                         req_i,
  vpd_rsp_if.source                       rsp_o
);

  logic [vpd_pkg::CFG_DATA_W-1:0] metric_mode_q;
  logic [vpd_pkg::CFG_DATA_W-1:0] power_p_q;
  vpd_pkg::cmd_t                  cmd;
  vpd_pkg::sts_t                  sts;
  logic                           req_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_mode_q <= vpd_pkg::MODE_EUCL;
      power_p_q     <= vpd_pkg::POWER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vpd_pkg::REG_METRIC_MODE: metric_mode_q <= cfg_data_i;
        vpd_pkg::REG_POWER_P:     power_p_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req_i.ready = req_ready;

  vpd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_type_i    (req_i.req_type),
    .req_last_i    (req_i.last_elem),
    .req_ready_o   (req_ready),
    .metric_mode_i (metric_mode_q),
    .power_p_i     (power_p_q),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  vpd_dp #(
    .ELEM_BITS (ELEM_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .metric_mode_i  (metric_mode_q),
    .power_p_i      (power_p_q),
    .x_value_i      (req_i.x_value),
    .y_value_i      (req_i.y_value),
    .weight_row_i   (req_i.weight_row),
    .weight_col_i   (req_i.weight_col),
    .weight_value_i (req_i.weight_value),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .distance_o     (rsp_o.distance),
    .too_long_o     (rsp_o.too_long)
  );

endmodule

// File: hw/rtl/vpd_root.sv
// Iterative integer root unit (square, cube and fourth root), one result bit per
// pass through the square, power and compare states. Depends on vpd_pkg.
module vpd_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  vpd_pkg::root_k_e            k_i,
  input  logic [vpd_pkg::ACC_W-1:0]   value_i,
  output logic                        done_o,
  output logic [vpd_pkg::ROOT_W-1:0]  root_o
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_SQ   = 4'b0010,
    R_PW   = 4'b0100,
    R_CMP  = 4'b1000
  } rstate_e;

  localparam int BIT_W  = $clog2(vpd_pkg::ROOT_W);
  localparam int CUBE_H = 22;
  localparam int HI_W   = 2 * CUBE_H;
  localparam int PW_W   = vpd_pkg::ACC_W + 2;

  rstate_e                     state_q, state_d;
  vpd_pkg::root_k_e            k_q;
  logic [BIT_W-1:0]            b_q;
  logic [vpd_pkg::ROOT_W-1:0]  r_q;
  logic [vpd_pkg::ACC_W-1:0]   v_q;
  logic [vpd_pkg::ACC_W-1:0]   sq_q;
  logic [HI_W-1:0]             hi_q;
  logic [vpd_pkg::ACC_W-1:0]   lo_q;
  logic                        done_q;

  logic [vpd_pkg::ROOT_W-1:0]  cand;
  logic [vpd_pkg::ACC_W-1:0]   sq_c;
  logic [vpd_pkg::ACC_W-1:0]   quad_c;
  logic [HI_W-1:0]             cube_hi_c;
  logic [HI_W-1:0]             cube_lo_c;
  logic [PW_W-1:0]             pw_c;
  logic [BIT_W-1:0]            b_top;

  assign cand      = r_q | (vpd_pkg::ROOT_W'(1) << b_q);
  assign sq_c      = cand * cand;
  assign quad_c    = sq_q[vpd_pkg::ROOT_W-1:0] * sq_q[vpd_pkg::ROOT_W-1:0];
  assign cube_hi_c = sq_q[HI_W-1:CUBE_H] * cand[CUBE_H-1:0];
  assign cube_lo_c = sq_q[CUBE_H-1:0] * cand[CUBE_H-1:0];
  assign pw_c      = {hi_q, CUBE_H'(0)} + {2'b00, lo_q};

  always_comb begin
    case (k_i)
      vpd_pkg::ROOT_CUBE: b_top = BIT_W'(CUBE_H - 1);
      vpd_pkg::ROOT_QUAD: b_top = BIT_W'(vpd_pkg::ROOT_W / 2 - 1);
      default:            b_top = BIT_W'(vpd_pkg::ROOT_W - 1);
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      R_IDLE:  if (start_i) state_d = R_SQ;
      R_SQ:    state_d = R_PW;
      R_PW:    state_d = R_CMP;
      R_CMP:   state_d = (b_q == '0) ? R_IDLE : R_SQ;
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == R_CMP) && (b_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      R_IDLE: begin
        if (start_i) begin
          k_q <= k_i;
          b_q <= b_top;
          r_q <= '0;
          v_q <= value_i;
        end
      end
      R_SQ: sq_q <= sq_c;
      R_PW: begin
        case (k_q)
          vpd_pkg::ROOT_QUAD: begin
            hi_q <= '0;
            lo_q <= quad_c;
          end
          vpd_pkg::ROOT_CUBE: begin
            hi_q <= cube_hi_c;
            lo_q <= vpd_pkg::ACC_W'(cube_lo_c);
          end
          default: begin
            hi_q <= '0;
            lo_q <= sq_q;
          end
        endcase
      end
      R_CMP: begin
        if (pw_c <= {2'b00, v_q}) r_q <= cand;
        b_q <= b_q - BIT_W'(1);
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign root_o = r_q;

endmodule

// File: hw/rtl/vpd_dp.sv
// Datapath: difference, powers, saturating accumulator, difference and weight
// memories, quadratic form, root unit and output register. Depends on vpd_pkg, vpd_root.
module vpd_dp #(
  parameter int ELEM_BITS = vpd_pkg::ELEM_BITS_DEF,
  parameter int MAX_DIM   = vpd_pkg::MAX_DIM_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vpd_pkg::cmd_t                       cmd_i,
  output vpd_pkg::sts_t                       sts_o,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]      metric_mode_i,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]      power_p_i,
  input  logic signed [ELEM_BITS-1:0]         x_value_i,
  input  logic signed [ELEM_BITS-1:0]         y_value_i,
  input  logic [vpd_pkg::WIDX_W-1:0]          weight_row_i,
  input  logic [vpd_pkg::WIDX_W-1:0]          weight_col_i,
  input  logic signed [vpd_pkg::W_BITS-1:0]   weight_value_i,
  input  logic                                rsp_ready_i,
  output logic                                rsp_valid_o,
  output logic [vpd_pkg::DIST_W-1:0]          distance_o,
  output logic                                too_long_o
);

  localparam int DW       = ELEM_BITS + 1;
  localparam int AW       = ELEM_BITS;
  localparam int SQ_W     = 2 * AW;
  localparam int PW_W     = 4 * AW;
  localparam int CNT_W    = $clog2(MAX_DIM + 1);
  localparam int MAHA_DIM = (MAX_DIM < vpd_pkg::WDIM) ? MAX_DIM : vpd_pkg::WDIM;
  localparam int DA_W     = (MAHA_DIM > 1) ? $clog2(MAHA_DIM) : 1;
  localparam int PROD_W   = vpd_pkg::W_BITS + DW;
  localparam int ROW_W    = PROD_W + vpd_pkg::WIDX_W;
  localparam int T_W      = ROW_W + DW;
  localparam int Q_W      = T_W + vpd_pkg::WIDX_W;
  localparam int ACC_W    = vpd_pkg::ACC_W;
  localparam int DIST_W   = vpd_pkg::DIST_W;

  logic signed [DW-1:0]            diff_mem [MAHA_DIM];
  logic signed [vpd_pkg::W_BITS-1:0] w_mem [vpd_pkg::WDIM * vpd_pkg::WDIM];

  logic [AW-1:0]                   ad_q;
  logic [SQ_W-1:0]                 sq_q;
  logic [PW_W-1:0]                 pw_q;
  logic [ACC_W-1:0]                acc_q;
  logic [CNT_W-1:0]                count_q;
  logic                            ovf_q;
  logic [DA_W-1:0]                 i_q, j_q, nm1_q;
  logic signed [DW-1:0]            diff_rd_q;
  logic signed [vpd_pkg::W_BITS-1:0] w_rd_q;
  logic signed [PROD_W-1:0]        prod_q;
  logic signed [ROW_W-1:0]         row_q;
  logic signed [T_W-1:0]           t_q;
  logic signed [Q_W-1:0]           q_q;
  logic [DIST_W-1:0]               res_q;
  logic                            out_valid_q;
  logic [DIST_W-1:0]               out_dist_q;
  logic                            out_long_q;

  logic signed [DW-1:0]            d_c;
  logic [DW-1:0]                   ad_c;
  logic [PW_W-1:0]                 pw3_c, pw4_c;
  logic [ACC_W-1:0]                op_c;
  logic [ACC_W:0]                  sum_c;
  logic signed [PROD_W-1:0]        prod_c;
  logic signed [T_W-1:0]           t_c;
  logic [Q_W-1:0]                  qa_c;
  logic [ACC_W-1:0]                root_in_c;
  logic                            root_done;
  logic [vpd_pkg::ROOT_W-1:0]      root_val;
  logic [DA_W-1:0]                 d_rd_addr;
  logic [DIST_W-1:0]               acc_sat_c, root_sat_c;
  logic                            store_c;

  assign d_c    = $signed({x_value_i[ELEM_BITS-1], x_value_i})
                - $signed({y_value_i[ELEM_BITS-1], y_value_i});
  assign ad_c   = d_c[DW-1] ? (DW'(0) - d_c) : d_c;
  assign pw3_c  = sq_q * ad_q;
  assign pw4_c  = sq_q * sq_q;
  assign prod_c = w_rd_q * diff_rd_q;
  assign t_c    = row_q * diff_rd_q;
  assign qa_c   = q_q[Q_W-1] ? (Q_W'(0) - q_q) : q_q;
  assign store_c = (metric_mode_i == vpd_pkg::MODE_MAHA) && (count_q < CNT_W'(MAHA_DIM));

  always_comb begin
    case (metric_mode_i)
      vpd_pkg::MODE_MANH: op_c = ACC_W'(ad_q);
      vpd_pkg::MODE_MINK: op_c = ACC_W'(pw_q);
      default:            op_c = ACC_W'(sq_q);
    endcase
  end
  assign sum_c = {1'b0, acc_q} + {1'b0, op_c};

  assign root_in_c  = cmd_i.root_q_src ? ACC_W'(qa_c) : acc_q;
  assign acc_sat_c  = (acc_q > ACC_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : acc_q[DIST_W-1:0];
  assign root_sat_c = (root_val > vpd_pkg::ROOT_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                                    : root_val[DIST_W-1:0];
  assign d_rd_addr  = cmd_i.m_rd_di ? i_q : j_q;

  vpd_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .k_i     (cmd_i.root_k),
    .value_i (root_in_c),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_take && store_c) diff_mem[count_q[DA_W-1:0]] <= d_c;
    if (cmd_i.m_rd_row || cmd_i.m_rd_di) diff_rd_q <= diff_mem[d_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wgt_take) w_mem[{weight_row_i, weight_col_i}] <= weight_value_i;
    if (cmd_i.m_rd_row) w_rd_q <= w_mem[{vpd_pkg::WIDX_W'(i_q), vpd_pkg::WIDX_W'(j_q)}];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.pair_take) ad_q <= ad_c[AW-1:0];
    if (cmd_i.mul_sq) sq_q <= ad_q * ad_q;
    if (cmd_i.mul_pw) pw_q <= vpd_pkg::is_quad(power_p_i) ? pw4_c : pw3_c;
    if (cmd_i.m_prod) prod_q <= prod_c;
    if (cmd_i.m_dmul) t_q <= t_c;
    if (cmd_i.res_acc) res_q <= acc_sat_c;
    else if (cmd_i.res_root) res_q <= root_sat_c;
    if (cmd_i.out_load) begin
      out_dist_q <= res_q;
      out_long_q <= ovf_q;
    end
  end

  // vector state and quadratic form sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      nm1_q       <= '0;
      row_q       <= '0;
      q_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.pair_take) begin
        if (count_q >= CNT_W'(MAX_DIM)) ovf_q <= 1'b1;
        else count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.acc_upd) begin
        case (metric_mode_i)
          vpd_pkg::MODE_MAX:  if (ACC_W'(ad_q) > acc_q) acc_q <= ACC_W'(ad_q);
          vpd_pkg::MODE_MAHA: ;
          default:            acc_q <= sum_c[ACC_W] ? {ACC_W{1'b1}} : sum_c[ACC_W-1:0];
        endcase
      end
      if (cmd_i.m_init) begin
        i_q   <= '0;
        j_q   <= '0;
        row_q <= '0;
        q_q   <= '0;
        nm1_q <= (count_q >= CNT_W'(MAHA_DIM)) ? DA_W'(MAHA_DIM - 1)
                                                : DA_W'(count_q - CNT_W'(1));
      end
      if (cmd_i.m_row) begin
        row_q <= row_q + ROW_W'(prod_q);
        if (j_q != nm1_q) j_q <= j_q + DA_W'(1);
      end
      if (cmd_i.m_q) begin
        q_q   <= q_q + Q_W'(t_q);
        row_q <= '0;
        j_q   <= '0;
        if (i_q != nm1_q) i_q <= i_q + DA_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        acc_q       <= '0;
        count_q     <= '0;
        ovf_q       <= 1'b0;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.j_last    = (j_q == nm1_q);
  assign sts_o.i_last    = (i_q == nm1_q);
  assign sts_o.root_done = root_done;
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign too_long_o  = out_long_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_DIM))
    else $error("element count beyond maximum dimension");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CNT_W'(MAX_DIM)))
    else $error("overflow flag without full count");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> (count_q == '0) && !ovf_q && (acc_q == '0))
    else $error("vector state not cleared after result");

endmodule

// File: hw/rtl/vpd_ctrl.sv
// Controller state machine: request intake, per-element power and accumulate,
// quadratic form loops, root start and result hand-off. Depends on vpd_pkg.
module vpd_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic                            req_type_i,
  input  logic                            req_last_i,
  output logic                            req_ready_o,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]  metric_mode_i,
  input  logic [vpd_pkg::CFG_DATA_W-1:0]  power_p_i,
  input  vpd_pkg::sts_t                   sts_i,
  output vpd_pkg::cmd_t                   cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_MUL1   = 13'b0000000000010,
    ST_MUL2   = 13'b0000000000100,
    ST_ACC    = 13'b0000000001000,
    ST_FIN    = 13'b0000000010000,
    ST_M_ADDR = 13'b0000000100000,
    ST_M_MUL  = 13'b0000001000000,
    ST_M_ROW  = 13'b0000010000000,
    ST_M_DI   = 13'b0000100000000,
    ST_M_DMUL = 13'b0001000000000,
    ST_M_Q    = 13'b0010000000000,
    ST_ROOT   = 13'b0100000000000,
    ST_OUT    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   last_q;
  logic   maha_root_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_type_i == vpd_pkg::REQ_WEIGHT) begin
            cmd_o.wgt_take = 1'b1;
          end else begin
            cmd_o.pair_take = 1'b1;
            state_d         = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_pw = 1'b1;
        state_d      = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_upd = 1'b1;
        state_d       = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        case (metric_mode_i)
          vpd_pkg::MODE_MAX, vpd_pkg::MODE_MANH: begin
            cmd_o.res_acc = 1'b1;
            state_d       = ST_OUT;
          end
          vpd_pkg::MODE_MAHA: begin
            cmd_o.m_init = 1'b1;
            state_d      = ST_M_ADDR;
          end
          vpd_pkg::MODE_MINK: begin
            cmd_o.root_start = 1'b1;
            cmd_o.root_k     = vpd_pkg::is_quad(power_p_i) ? vpd_pkg::ROOT_QUAD
                                                           : vpd_pkg::ROOT_CUBE;
            state_d          = ST_ROOT;
          end
          default: begin
            cmd_o.root_start = 1'b1;
            cmd_o.root_k     = vpd_pkg::ROOT_SQ;
            state_d          = ST_ROOT;
          end
        endcase
      end
      ST_M_ADDR: begin
        cmd_o.m_rd_row = 1'b1;
        state_d        = ST_M_MUL;
      end
      ST_M_MUL: begin
        cmd_o.m_prod = 1'b1;
        state_d      = ST_M_ROW;
      end
      ST_M_ROW: begin
        cmd_o.m_row = 1'b1;
        state_d     = sts_i.j_last ? ST_M_DI : ST_M_ADDR;
      end
      ST_M_DI: begin
        cmd_o.m_rd_di = 1'b1;
        state_d       = ST_M_DMUL;
      end
      ST_M_DMUL: begin
        cmd_o.m_dmul = 1'b1;
        state_d      = ST_M_Q;
      end
      ST_M_Q: begin
        cmd_o.m_q = 1'b1;
        state_d   = sts_i.i_last ? ST_ROOT : ST_M_ADDR;
      end
      ST_ROOT: begin
        if (maha_root_q) begin
          cmd_o.root_start = 1'b1;
          cmd_o.root_k     = vpd_pkg::ROOT_SQ;
          cmd_o.root_q_src = 1'b1;
        end
        if (sts_i.root_done) begin
          cmd_o.res_root = 1'b1;
          state_d        = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // quadratic form sum is complete in the cycle after the last row term
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maha_root_q <= 1'b0;
    end else begin
      maha_root_q <= (state_q == ST_M_Q) && sts_i.i_last;
    end
  end

  vpd_pkg::cmd_t cmd_c;
  always_comb begin
    cmd_c = cmd_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.pair_take) last_q <= req_last_i;
    end
  end

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_c.out_load |-> sts_i.out_free)
    else $error("result loaded over a pending result");

  a_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.root_done |-> (state_q == ST_ROOT))
    else $error("root finished outside of root wait");

  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> last_q)
    else $error("finish without a last element");

  a_maha_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    maha_root_q |-> (state_q == ST_ROOT))
    else $error("quadratic form done but root not pending");

endmodule
